### rtl/core/gpc_pkg.sv
// Package for the gripper position command core: fixed-point constants,
// state enums, register codes and the CORDIC arctangent table.
// No dependencies.
package gpc_pkg;

   typedef logic signed [33:0] q30_type;
   typedef logic signed [19:0] q16_type;

   localparam q30_type Q30_R       = 34'sd34896609;
   localparam q30_type Q30_E       = 34'sd15633681;
   localparam q30_type Q30_P0      = 34'sd2548872303;
   localparam q30_type Q30_HALF_PI = 34'sd1686629713;
   localparam q30_type Q30_PI      = 34'sd3373259426;
   localparam q30_type Q30_TOL     = 34'sd1074;
   localparam q30_type CORDIC_GAIN = 34'sd652032874;

   localparam int      SQ_W        = 53;
   localparam logic [SQ_W-1:0] Q60_LL = 53'd3878427967404676;

   localparam q16_type ANG_MAX      = 20'sd109445;
   localparam q16_type BACKOFF_STEP = 20'sd655;
   localparam logic signed [21:0] WID_MAX = 22'sd102760;
   localparam logic [17:0] FBW_MAX  = 18'd262143;

   localparam logic [1:0] CSR_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_MARGIN = 2'd1;
   localparam logic [1:0] CSR_MIT    = 2'd2;

   localparam logic [7:0] OPC_MIT = 8'd22;
   localparam logic [7:0] OPC_PV  = 8'd23;

   typedef enum logic [2:0] {
      W_IDLE, W_CORDIC, W_MUL_H, W_MUL_W, W_MUL_D, W_RAD, W_SQRT
   } wid_state_type;

   typedef enum logic [2:0] {
      S_IDLE, S_W0_GO, S_W0, S_BIS_GO, S_BIS, S_FB_GO, S_FB, S_FIN
   } core_state_type;

   function automatic q30_type atan_q30(input logic [4:0] i);
      q30_type t;
      unique case (i)
         5'd0:  t = 34'sd843314857;
         5'd1:  t = 34'sd497837829;
         5'd2:  t = 34'sd263043837;
         5'd3:  t = 34'sd133525159;
         5'd4:  t = 34'sd67021687;
         5'd5:  t = 34'sd33543516;
         5'd6:  t = 34'sd16775851;
         5'd7:  t = 34'sd8388437;
         5'd8:  t = 34'sd4194283;
         5'd9:  t = 34'sd2097149;
         5'd10: t = 34'sd1048576;
         default: t = q30_type'(34'd1 << (5'd30 - i));
      endcase
      return t;
   endfunction

endpackage

### rtl/core/gpc_chan_if.sv
// Channel interfaces of the gripper position command core: request,
// response and register write channels. No dependencies.
interface gpc_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic               use_width;
   logic signed [20:0] target_width;
   logic signed [18:0] target_angle;
   logic signed [18:0] measured_angle;
   logic signed [15:0] measured_current;
   modport source(output valid, cmd, use_width, target_width, target_angle,
                  measured_angle, measured_current, input ready);
   modport sink(input valid, cmd, use_width, target_width, target_angle,
                measured_angle, measured_current, output ready);
endinterface

interface gpc_rsp_if;
   logic               valid;
   logic               ready;
   logic               send_cmd;
   logic [7:0]         opcode;
   logic signed [17:0] cmd_angle;
   logic [17:0]        feedback_width;
   logic               angle_clamped;
   logic               is_backoff;
   modport source(output valid, send_cmd, opcode, cmd_angle, feedback_width,
                  angle_clamped, is_backoff, input ready);
   modport sink(input valid, send_cmd, opcode, cmd_angle, feedback_width,
                angle_clamped, is_backoff, output ready);
endinterface

interface gpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [15:0] wdata;
   modport source(output valid, addr, wdata, input ready);
   modport sink(input valid, addr, wdata, output ready);
endinterface

### rtl/core/gpc_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on gpc_pkg.
module gpc_cordic import gpc_pkg::*; #(
   parameter int CORDIC_STEPS = 18
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  q30_type z_in,
   output logic    done,
   output q30_type cos_out,
   output q30_type sin_out
);
   localparam int IW = $clog2(CORDIC_STEPS);

   q30_type x_ff, y_ff, z_ff;
   logic [IW-1:0] i_ff;
   logic busy_ff, done_ff;
   q30_type dx, dy, t;

   always_comb begin
      dx = x_ff >>> i_ff;
      dy = y_ff >>> i_ff;
      t  = atan_q30(5'(i_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && i_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= CORDIC_GAIN;
         y_ff <= '0;
         z_ff <= z_in;
         i_ff <= '0;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - dy;
            y_ff <= y_ff + dx;
            z_ff <= z_ff - t;
         end else begin
            x_ff <= x_ff + dy;
            y_ff <= y_ff - dx;
            z_ff <= z_ff + t;
         end
         i_ff <= i_ff + 1'b1;
      end
   end

   assign done    = done_ff;
   assign cos_out = x_ff;
   assign sin_out = y_ff;
endmodule

### rtl/core/gpc_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on gpc_pkg.
module gpc_isqrt import gpc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] rad_in,
   output logic            done,
   output logic [26:0]     root
);
   logic [SQ_W-1:0] n_ff, r_ff, b_ff, trial;
   logic [4:0] cnt_ff;
   logic busy_ff, done_ff;

   assign trial = r_ff + b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd26) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= rad_in;
         r_ff   <= '0;
         b_ff   <= SQ_W'(1) << 52;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_ff <= n_ff - trial;
            r_ff <= (r_ff >> 1) + b_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         b_ff   <= b_ff >> 2;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign root = r_ff[26:0];
endmodule

### rtl/core/gpc_width.sv
// Linkage width evaluator: CORDIC, one shared multiplier and square root.
// Depends on gpc_pkg, gpc_cordic, gpc_isqrt.
module gpc_width import gpc_pkg::*; #(
   parameter int CORDIC_STEPS = 18
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  q30_type angle,
   output logic    done,
   output q30_type width
);
   wid_state_type state_ff, state_in;
   q30_type z, zc, c_val, s_val;
   logic swap_ff;
   logic cor_start, cor_done, sq_start, sq_done;
   logic [26:0] root;
   logic signed [31:0] mul_a, mul_b, h_ff, wd_ff, d;
   logic signed [63:0] prod, dd_ff, rad_s;
   logic [SQ_W-1:0] rad;

   assign z  = Q30_P0 - angle;
   assign zc = (z > Q30_HALF_PI) ? z - Q30_HALF_PI : z;

   gpc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .z_in(zc),
      .done(cor_done), .cos_out(c_val), .sin_out(s_val)
   );

   assign d     = h_ff - 32'(Q30_E);
   assign rad_s = $signed({11'b0, Q60_LL}) - dd_ff;
   assign rad   = rad_s[63] ? '0 : rad_s[SQ_W-1:0];

   gpc_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start), .rad_in(rad),
      .done(sq_done), .root(root)
   );

   always_comb begin
      mul_a = 32'(Q30_R);
      mul_b = d;
      if (state_ff == W_MUL_H) mul_b = swap_ff ? 32'(c_val) : 32'(s_val);
      if (state_ff == W_MUL_W) mul_b = swap_ff ? -32'(s_val) : 32'(c_val);
      if (state_ff == W_MUL_D) mul_a = d;
      prod = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= W_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == W_IDLE && start) swap_ff <= (z > Q30_HALF_PI);
      if (state_ff == W_MUL_H) h_ff  <= 32'(prod >>> 30);
      if (state_ff == W_MUL_W) wd_ff <= 32'(prod >>> 30);
      if (state_ff == W_MUL_D) dd_ff <= prod;
   end

   always_comb begin
      state_in  = state_ff;
      cor_start = 1'b0;
      sq_start  = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         W_IDLE:   if (start) begin
            cor_start = 1'b1;
            state_in  = W_CORDIC;
         end
         W_CORDIC: if (cor_done) state_in = W_MUL_H;
         W_MUL_H:  state_in = W_MUL_W;
         W_MUL_W:  state_in = W_MUL_D;
         W_MUL_D:  state_in = W_RAD;
         W_RAD: begin
            sq_start = 1'b1;
            state_in = W_SQRT;
         end
         W_SQRT:   if (sq_done) begin
            done     = 1'b1;
            state_in = W_IDLE;
         end
         default:  state_in = W_IDLE;
      endcase
   end

   assign width = $signed({7'b0, root}) + q30_type'(wd_ff);
endmodule

### rtl/core/gripper_position_command_core.sv
// Top level of the gripper position command core: handshakes, registers,
// bisection sequencer. Depends on gpc_pkg, gpc_chan_if, gpc_width.
//
//  channel  | dir | beat
//  req_bus  | in  | position request or motor feedback report
//  rsp_bus  | out | one result per request beat
//  csr_bus  | in  | register write (limit, margin, mode), always ready
//
// Angle request: no width evaluation, straight to S_FIN. Width request: one width
// evaluation for w(0) and up to BISECT_STEPS more, each on the shared width unit.
// Feedback: two evaluations. Reset is synchronous; req_bus.ready is low while
// an item is in work. A finished result waits in the output register while the
// next item may enter.
module gripper_position_command_core import gpc_pkg::*; #(
   parameter int BISECT_STEPS = 24,
   parameter int CORDIC_STEPS = 18
) (
   input  logic clock,
   input  logic reset,
   gpc_req_if.sink   req_bus,
   gpc_rsp_if.source rsp_bus,
   gpc_csr_if.sink   csr_bus
);
   localparam int BW = $clog2(BISECT_STEPS);

   core_state_type state_ff, state_in;
   logic [14:0] limit_ff, margin_ff;
   logic mit_ff;
   q16_type last_ff, mangle_ff;
   logic signed [15:0] mcur_ff;

   logic cmd_ff, usew_ff;
   logic signed [20:0] tw_ff;
   logic signed [18:0] ta_ff, ma_ff;
   logic signed [15:0] mc_ff;

   q30_type w0_ff, wa_ff, tgt_ff, lo_ff, hi_ff, mid_ff, res_ff;
   logic [BW-1:0] cnt_ff;

   logic w_start, w_done;
   q30_type w_angle, w_out, mid, diff, lo_n, hi_n;
   logic hit;

   logic signed [21:0] wclamp;
   q16_type fb_a, req_a, tgt_a, cand;
   logic fb_clamped;
   logic [16:0] mag_stored, mag_in;
   logic drop, over, sup, slot_free, load;
   logic signed [34:0] v, vr;
   logic [17:0] fbw;

   logic rsp_valid_ff, send_ff, clamp_ff, boff_ff;
   logic [7:0] opc_ff;
   logic signed [17:0] cang_ff;
   logic [17:0] fbw_ff;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= 15'd1000;
         margin_ff <= 15'd500;
         mit_ff    <= 1'b1;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            CSR_LIMIT:  limit_ff  <= csr_bus.wdata[14:0];
            CSR_MARGIN: margin_ff <= csr_bus.wdata[14:0];
            CSR_MIT:    mit_ff    <= csr_bus.wdata[0];
            default:    ;
         endcase
      end
   end

   // feedback angle clamp
   always_comb begin
      fb_clamped = 1'b1;
      if (ma_ff < 0)                    fb_a = '0;
      else if (20'(ma_ff) > ANG_MAX)    fb_a = ANG_MAX;
      else begin
         fb_a       = 20'(ma_ff);
         fb_clamped = 1'b0;
      end
   end

   always_comb begin
      wclamp = 22'(tw_ff);
      if (wclamp > WID_MAX) wclamp = WID_MAX;
      if (wclamp < 0)       wclamp = '0;
   end

   assign mid = (lo_ff + hi_ff) >>> 1;

   always_comb begin
      w_angle = '0;
      if (state_ff == S_BIS_GO) w_angle = mid;
      if (state_ff == S_FB_GO)  w_angle = q30_type'(fb_a) <<< 14;
      w_start = (state_ff == S_W0_GO) || (state_ff == S_BIS_GO) ||
                (state_ff == S_FB_GO);
   end

   gpc_width #(.CORDIC_STEPS(CORDIC_STEPS)) u_width (
      .clock(clock), .reset(reset), .start(w_start), .angle(w_angle),
      .done(w_done), .width(w_out)
   );

   assign diff = w_out - tgt_ff;
   assign hit  = (diff < Q30_TOL) && (diff > -Q30_TOL);
   assign lo_n = (w_out < tgt_ff) ? mid_ff : lo_ff;
   assign hi_n = (w_out < tgt_ff) ? hi_ff : mid_ff;

   // result assembly
   always_comb begin
      cand = usew_ff ? 20'((res_ff + 34'sd8192) >>> 14) : 20'(ta_ff);
      if (cand > ANG_MAX) req_a = ANG_MAX;
      else if (cand < 0)  req_a = '0;
      else                req_a = cand;
      mag_stored = mcur_ff[15] ? 17'(-18'(mcur_ff)) : 17'(mcur_ff);
      mag_in     = mc_ff[15] ? 17'(-18'(mc_ff)) : 17'(mc_ff);
      drop = (limit_ff != '0) && (mag_stored > 17'(limit_ff)) &&
             ((mcur_ff < 0 && req_a < mangle_ff) ||
              (mcur_ff > 0 && req_a > mangle_ff));
      over  = (limit_ff != '0) && (mag_in > (17'(limit_ff) + 17'(margin_ff)));
      tgt_a = mc_ff[15] ? fb_a + BACKOFF_STEP : fb_a - BACKOFF_STEP;
      sup   = mc_ff[15] ? (last_ff > tgt_a) : (last_ff < tgt_a);
      v  = 35'(wa_ff - w0_ff) <<< 1;
      vr = (v + 35'sd512) >>> 10;
      if (v <= 0)                fbw = '0;
      else if (vr > 35'(FBW_MAX)) fbw = FBW_MAX;
      else                       fbw = vr[17:0];
   end

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign load      = (state_ff == S_FIN) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_bus.valid) begin
            state_in = (!req_bus.cmd && !req_bus.use_width) ? S_FIN : S_W0_GO;
         end
         S_W0_GO:  state_in = S_W0;
         S_W0:     if (w_done) state_in = cmd_ff ? S_FB_GO : S_BIS_GO;
         S_BIS_GO: state_in = S_BIS;
         S_BIS:    if (w_done) begin
            state_in = (hit || cnt_ff == BW'(BISECT_STEPS - 1)) ? S_FIN : S_BIS_GO;
         end
         S_FB_GO:  state_in = S_FB;
         S_FB:     if (w_done) state_in = S_FIN;
         S_FIN:    if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_bus.valid) begin
         cmd_ff  <= req_bus.cmd;
         usew_ff <= req_bus.use_width;
         tw_ff   <= req_bus.target_width;
         ta_ff   <= req_bus.target_angle;
         ma_ff   <= req_bus.measured_angle;
         mc_ff   <= req_bus.measured_current;
      end
      if (state_ff == S_W0 && w_done) begin
         w0_ff  <= w_out;
         tgt_ff <= (q30_type'(wclamp) <<< 9) + w_out;
         lo_ff  <= '0;
         hi_ff  <= Q30_PI;
         cnt_ff <= '0;
      end
      if (state_ff == S_BIS_GO) mid_ff <= mid;
      if (state_ff == S_BIS && w_done) begin
         lo_ff  <= lo_n;
         hi_ff  <= hi_n;
         cnt_ff <= cnt_ff + 1'b1;
         res_ff <= hit ? mid_ff : (lo_n + hi_n) >>> 1;
      end
      if (state_ff == S_FB && w_done) wa_ff <= w_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= -20'sd65536;
         mangle_ff <= '0;
         mcur_ff   <= '0;
      end else if (load) begin
         if (!cmd_ff) begin
            if (!drop) last_ff <= req_a;
         end else begin
            mangle_ff <= fb_a;
            mcur_ff   <= mc_ff;
            if (over && !sup) last_ff <= fb_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (load) rsp_valid_ff <= 1'b1;
      else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         send_ff  <= 1'b0;
         opc_ff   <= '0;
         cang_ff  <= '0;
         fbw_ff   <= '0;
         clamp_ff <= 1'b0;
         boff_ff  <= 1'b0;
         if (!cmd_ff) begin
            if (!drop) begin
               send_ff <= 1'b1;
               opc_ff  <= mit_ff ? OPC_MIT : OPC_PV;
               cang_ff <= 18'(req_a);
            end
         end else begin
            fbw_ff   <= fbw;
            clamp_ff <= fb_clamped;
            if (over && !sup) begin
               send_ff <= 1'b1;
               opc_ff  <= mit_ff ? OPC_MIT : OPC_PV;
               cang_ff <= 18'(tgt_a);
               boff_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.send_cmd       = send_ff;
   assign rsp_bus.opcode         = opc_ff;
   assign rsp_bus.cmd_angle      = cang_ff;
   assign rsp_bus.feedback_width = fbw_ff;
   assign rsp_bus.angle_clamped  = clamp_ff;
   assign rsp_bus.is_backoff     = boff_ff;
endmodule

### tb/tb_gripper_position_command_core.sv
// Self-checking testbench for gripper_position_command_core: random and directed
// request/feedback beats, register phases, scoreboard with a bit-true predictor.
// Depends on gpc_pkg and gpc_chan_if from the RTL.
module tb_gripper_position_command_core;
   import gpc_pkg::*;

   localparam logic [1:0] CSR_NONE = 2'd3;

   typedef struct {
      bit               cmd;
      bit               use_width;
      logic signed [20:0] target_width;
      logic signed [18:0] target_angle;
      logic signed [18:0] measured_angle;
      logic signed [15:0] measured_current;
   } item_type;

   typedef struct packed {
      logic               send_cmd;
      logic [7:0]         opcode;
      logic signed [17:0] cmd_angle;
      logic [17:0]        feedback_width;
      logic               angle_clamped;
      logic               is_backoff;
   } result_type;

   class gripper_scoreboard;
      longint     limit, margin;
      bit         mit;
      longint     last_cmd, motor_ang, motor_cur;
      result_type pending[$];

      function new();
         limit = 1000; margin = 500; mit = 1;
         last_cmd = -65536; motor_ang = 0; motor_cur = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] v);
         case (idx)
            CSR_LIMIT:  limit  = v[14:0];
            CSR_MARGIN: margin = v[14:0];
            CSR_MIT:    mit    = v[0];
            default: ;
         endcase
      endfunction

      function void sincos(longint z0, output longint c, output longint s);
         longint x, y, z, t, dx, dy;
         x = 652032874; y = 0; z = z0;
         for (int i = 0; i < 18; i++) begin
            t = (i < 11) ? longint'(atan_q30(5'(i))) : (longint'(1) <<< (30 - i));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= t;
            end else begin
               x += dx; y -= dy; z += t;
            end
         end
         c = x;
         s = y;
      endfunction

      function longint root(longint n0);
         longint unsigned n, r, b;
         n = n0; r = 0; b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return longint'(r);
      endfunction

      function longint linkage_width(longint a);
         longint z, c, s, sn, cs, h, wd, d, rad;
         z = longint'(Q30_P0) - a;
         if (z > 1686629713) begin
            sincos(z - 1686629713, c, s);
            sn = c; cs = -s;
         end else begin
            sincos(z, c, s);
            sn = s; cs = c;
         end
         h  = (34896609 * sn) >>> 30;
         wd = (34896609 * cs) >>> 30;
         d = h - 15633681;
         rad = 62277026 * 62277026 - d * d;
         if (rad < 0) rad = 0;
         return root(rad) + wd;
      endfunction

      function longint width_to_angle(longint w);
         longint tgt, lo, hi, mid, cur, diff, res;
         bit hit;
         tgt = (w <<< 9) + linkage_width(0);
         lo = 0; hi = longint'(Q30_PI); mid = 0; hit = 0;
         for (int i = 0; i < 24; i++) begin
            mid = (lo + hi) >>> 1;
            cur = linkage_width(mid);
            diff = cur - tgt;
            if (diff < 1074 && diff > -1074) begin
               hit = 1;
               break;
            end
            if (cur < tgt) lo = mid; else hi = mid;
         end
         res = hit ? mid : ((lo + hi) >>> 1);
         return (res + 8192) >>> 14;
      endfunction

      function void note_item(item_type it);
         result_type r;
         longint a, cur, mag, v, stp, tgt;
         r = '{default: 0};
         if (!it.cmd) begin
            if (it.use_width) begin
               a = it.target_width;
               if (a > 102760) a = 102760;
               if (a < 0) a = 0;
               a = width_to_angle(a);
            end else a = it.target_angle;
            if (a > 109445) a = 109445;
            if (a < 0) a = 0;
            mag = motor_cur < 0 ? -motor_cur : motor_cur;
            if (!(limit > 0 && mag > limit &&
                  ((motor_cur < 0 && a < motor_ang) ||
                   (motor_cur > 0 && a > motor_ang)))) begin
               r.send_cmd = 1; r.opcode = mit ? OPC_MIT : OPC_PV; r.cmd_angle = a;
               last_cmd = a;
            end
         end else begin
            a = it.measured_angle;
            cur = it.measured_current;
            mag = cur < 0 ? -cur : cur;
            if (a < 0) begin
               a = 0; r.angle_clamped = 1;
            end else if (a > 109445) begin
               a = 109445; r.angle_clamped = 1;
            end
            v = 2 * (linkage_width(a <<< 14) - linkage_width(0));
            if (v > 0) begin
               v = (v + 512) >>> 10;
               r.feedback_width = (v > 262143) ? 262143 : v;
            end
            motor_ang = a;
            motor_cur = cur;
            if (limit > 0 && mag > limit + margin) begin
               stp = cur < 0 ? 655 : -655;
               tgt = a + stp;
               if (!((stp > 0 && last_cmd > tgt) || (stp < 0 && last_cmd < tgt))) begin
                  r.send_cmd = 1; r.opcode = mit ? OPC_MIT : OPC_PV;
                  r.cmd_angle = tgt; r.is_backoff = 1;
                  last_cmd = a;
               end
            end
         end
         pending = {pending, r};
      endfunction

      function bit check_result(result_type got, output string msg);
         result_type e;
         if (pending.size() == 0) begin
            msg = "result beat with nothing expected";
            return 1;
         end
         e = pending.pop_front();
         if (got !== e) begin
            $sformat(msg, {"got send=%0d op=%0d ang=%0d fbw=%0d clp=%0d bo=%0d ",
                           "exp %0d %0d %0d %0d %0d %0d"},
               got.send_cmd, got.opcode, got.cmd_angle, got.feedback_width, got.angle_clamped,
               got.is_backoff, e.send_cmd, e.opcode, e.cmd_angle, e.feedback_width,
               e.angle_clamped, e.is_backoff);
            return 1;
         end
         return 0;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   gpc_req_if req_bus();
   gpc_rsp_if rsp_bus();
   gpc_csr_if csr_bus();

   gripper_position_command_core dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   always #5 clock = ~clock;

   gripper_scoreboard sb = new();
   int  errors = 0;
   int  cycles = 0;
   int  hold_seq = 0, hold_seen = 0, hold_cnt = 0;
   logic [15:0] stall_mask = 16'hFFFF;
   logic [3:0]  stall_pos = 0;

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   initial begin
      req_bus.valid = 0; req_bus.cmd = 0; req_bus.use_width = 0;
      req_bus.target_width = 0; req_bus.target_angle = 0;
      req_bus.measured_angle = 0; req_bus.measured_current = 0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0; csr_bus.addr = CSR_LIMIT; csr_bus.wdata = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: rotating stall mask, plus one long hold-off on request
   always @(posedge clock) begin
      result_type got;
      string msg;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.send_cmd = rsp_bus.send_cmd; got.opcode = rsp_bus.opcode;
         got.cmd_angle = rsp_bus.cmd_angle; got.feedback_width = rsp_bus.feedback_width;
         got.angle_clamped = rsp_bus.angle_clamped; got.is_backoff = rsp_bus.is_backoff;
         if (sb.check_result(got, msg)) report(msg);
      end
      stall_pos <= stall_pos + 1;
      if (stall_pos == 0)
         stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_cnt <= 4000;
         rsp_bus.ready <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_bus.ready <= 0;
      end else
         rsp_bus.ready <= !reset && stall_mask[stall_pos];
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] v);
      csr_bus.valid <= 1; csr_bus.addr <= idx; csr_bus.wdata <= v;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, v);
      csr_bus.valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_beat(item_type it);
      req_bus.valid <= 1; req_bus.cmd <= it.cmd; req_bus.use_width <= it.use_width;
      req_bus.target_width <= it.target_width; req_bus.target_angle <= it.target_angle;
      req_bus.measured_angle <= it.measured_angle;
      req_bus.measured_current <= it.measured_current;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_item(it);
   endtask

   task automatic maybe_gap();
      if ($urandom_range(0, 5) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
   endtask

   function automatic item_type noise_item();
      item_type it;
      it.cmd = $urandom; it.use_width = $urandom;
      it.target_width = $urandom; it.target_angle = $urandom;
      it.measured_angle = $urandom; it.measured_current = $urandom;
      return it;
   endfunction

   function automatic item_type pick_item();
      item_type it;
      int k, c, th;
      it = noise_item();
      k = $urandom_range(0, 99);
      if (k < 15) begin
         it.cmd = 0; it.use_width = 1;
         if ($urandom_range(0, 7) != 0) it.target_width = $urandom_range(0, 102760);
      end else if (k < 45) begin
         it.cmd = 0; it.use_width = 0;
         if ($urandom_range(0, 7) != 0) it.target_angle = $urandom_range(0, 109445);
      end else begin
         it.cmd = 1;
         if ($urandom_range(0, 7) != 0) it.measured_angle = $urandom_range(0, 109445);
         th = (sb.limit + sb.margin > 32767) ? 32767 : sb.limit + sb.margin;
         case ($urandom_range(0, 3))
            0: c = th + $urandom_range(0, 6) - 3;
            1: c = sb.limit + $urandom_range(0, 6) - 3;
            2: c = $urandom_range(0, 32767);
            default: c = $urandom_range(0, 200);
         endcase
         if (c > 32767) c = 32767;
         if (c < 0) c = 0;
         it.measured_current = $urandom_range(0, 1) ? -c : c;
      end
      return it;
   endfunction

   function automatic item_type mk(bit cmd, bit uw, int w, int a, int ma, int mc);
      item_type it;
      it = noise_item();
      it.cmd = cmd; it.use_width = uw;
      if (!cmd && uw) it.target_width = w;
      if (!cmd && !uw) it.target_angle = a;
      if (cmd) begin
         it.measured_angle = ma; it.measured_current = mc;
      end
      return it;
   endfunction

   initial begin
      item_type dir[$];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir = '{mk(0, 0, 0, -262144, 0, 0), mk(0, 0, 0, 262143, 0, 0), mk(0, 0, 0, 0, 0, 0),
              mk(0, 0, 0, 109445, 0, 0), mk(0, 0, 0, 109446, 0, 0),
              mk(0, 1, -1048576, 0, 0, 0), mk(0, 1, 1048575, 0, 0, 0), mk(0, 1, 0, 0, 0, 0),
              mk(0, 1, 102760, 0, 0, 0), mk(0, 1, 51000, 0, 0, 0),
              mk(1, 0, 0, 0, -262144, 0), mk(1, 0, 0, 0, 262143, 32767),
              mk(1, 0, 0, 0, 109446, -32768), mk(1, 0, 0, 0, 0, 0),
              mk(1, 0, 0, 0, 50000, 2000), mk(0, 0, 0, 60000, 0, 0),
              mk(0, 0, 0, 40000, 0, 0), mk(1, 0, 0, 0, 50000, -2000),
              mk(0, 0, 0, 30000, 0, 0), mk(1, 0, 0, 0, 50000, 1501),
              mk(1, 0, 0, 0, 50000, 1500), mk(1, 0, 0, 0, 50000, 1001),
              mk(0, 0, 0, 70000, 0, 0)};
      foreach (dir[i]) begin
         send_beat(dir[i]);
         maybe_gap();
      end
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_LIMIT, 0); write_reg(CSR_MIT, 0);
            end
            1: begin
               write_reg(CSR_LIMIT, 16'hFFFF); write_reg(CSR_MARGIN, 0);
               write_reg(CSR_MIT, 16'hFFFE);
            end
            2: begin
               write_reg(CSR_LIMIT, 1); write_reg(CSR_MARGIN, 16'h7FFF);
               write_reg(CSR_MIT, 1); write_reg(CSR_NONE, 16'h1234);
            end
            3: begin
               write_reg(CSR_LIMIT, 16'h8000 | 16'($urandom_range(100, 5000)));
               write_reg(CSR_MARGIN, $urandom_range(0, 3000));
            end
            default: begin
               write_reg(CSR_LIMIT, $urandom_range(50, 3000));
               write_reg(CSR_MARGIN, $urandom_range(0, 2000));
               write_reg(CSR_MIT, $urandom);
            end
         endcase
         for (int n = 0; n < 100; n++) begin
            if (ph == 2 && n == 10) hold_seq <= hold_seq + 1;
            send_beat(pick_item());
            if (n % 37 == 36) begin
               req_bus.valid <= 0;
               while (sb.pending.size() != 0) @(posedge clock);
            end else maybe_gap();
         end
         drain();
      end

      if (errors == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         if (sb.pending.size() != 0) report("expected results left over");
         $display("status: fail");
      end
      $finish;
   end
endmodule
